// ----- src/led_driver_mode_controller_macros.svh -----
// Assertion helpers shared by the controller sources.
`ifndef LED_DRIVER_MODE_CONTROLLER_MACROS_SVH
`define LED_DRIVER_MODE_CONTROLLER_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define LDMC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define LDMC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/ldmc_pkg.sv -----
package ldmc_pkg;

  typedef enum logic [1:0] {
    CMD_POWER_ON = 2'd0,
    CMD_SETTLE   = 2'd1,
    CMD_VSAMPLE  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    CFG_GROUP_SELECT = 2'd0,
    CFG_MEMORY_EN    = 2'd1,
    CFG_LOW_THRESH   = 2'd2
  } cfg_idx_e;

  localparam int unsigned GROUP_COUNT    = 12;
  localparam int unsigned ROW_LEN        = 8;
  localparam int unsigned LOW_RUN        = 8;
  localparam int unsigned CONFIG_PRESSES = 9;

  localparam logic [7:0] LVL_SOS    = 8'd246;
  localparam logic [7:0] LVL_POLICE = 8'd248;
  localparam logic [7:0] LVL_BIKE   = 8'd250;
  localparam logic [7:0] LVL_BATT   = 8'd254;

  localparam logic [7:0] THRESH_RESET = 8'd120;

  localparam logic [7:0] GROUP_TABLE [GROUP_COUNT][ROW_LEN] = '{
    '{8'd1, 8'd2, 8'd3, 8'd5, 8'd7, LVL_POLICE, LVL_BIKE, LVL_BATT},
    '{8'd1, 8'd2, 8'd3, 8'd5, 8'd7, 8'd0, 8'd0, 8'd0},
    '{8'd7, 8'd5, 8'd3, 8'd2, 8'd1, 8'd0, 8'd0, 8'd0},
    '{8'd2, 8'd4, 8'd7, LVL_POLICE, LVL_BIKE, LVL_BATT, LVL_SOS, 8'd0},
    '{8'd2, 8'd4, 8'd7, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
    '{8'd7, 8'd4, 8'd2, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
    '{8'd1, 8'd2, 8'd3, 8'd6, LVL_POLICE, LVL_BIKE, LVL_BATT, LVL_SOS},
    '{8'd1, 8'd2, 8'd3, 8'd6, 8'd0, 8'd0, 8'd0, 8'd0},
    '{8'd6, 8'd3, 8'd2, 8'd1, 8'd0, 8'd0, 8'd0, 8'd0},
    '{8'd2, 8'd3, 8'd5, 8'd7, 8'd0, 8'd0, 8'd0, 8'd0},
    '{8'd7, 8'd4, LVL_POLICE, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
    '{8'd7, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0}
  };

  typedef struct packed {
    logic [7:0] duty;
    logic       fast;
  } level_out_t;

  // Count of nonzero entries ahead of the first zero in a row.
  function automatic logic [3:0] row_solid_count(logic [3:0] row);
    logic [3:0] n;
    logic       done;
    n    = '0;
    done = 1'b0;
    for (int i = 0; i < ROW_LEN; i++) begin
      if (!done && GROUP_TABLE[row][i] != 8'd0) begin
        n = n + 4'd1;
      end else begin
        done = 1'b1;
      end
    end
    return n;
  endfunction

  // Ramp duty by zero-based level; past the table the duty is full.
  function automatic logic [7:0] ramp_duty(logic [2:0] idx);
    logic [7:0] d;
    case (idx)
      3'd0:    d = 8'd1;
      3'd1:    d = 8'd7;
      3'd2:    d = 8'd32;
      3'd3:    d = 8'd63;
      3'd4:    d = 8'd107;
      3'd5:    d = 8'd127;
      3'd6:    d = 8'd255;
      default: d = 8'd255;
    endcase
    return d;
  endfunction

endpackage

// ----- src/ldmc_level_out.sv -----
module ldmc_level_out #(
  parameter int unsigned RAMP_LEVELS = 7
) (
  input  logic [7:0]          level_i,
  input  logic                powered_down_i,
  output ldmc_pkg::level_out_t out_o
);
  import ldmc_pkg::*;

  localparam logic [7:0] RampMax = 8'(RAMP_LEVELS);

  logic       solid;
  logic [7:0] lvl_m1;

  assign solid  = !powered_down_i && (level_i >= 8'd1) && (level_i <= RampMax);
  assign lvl_m1 = level_i - 8'd1;

  always_comb begin
    out_o = '0;
    if (solid) begin
      // levels past the ramp table run at full duty
      out_o.duty = (lvl_m1 < 8'd7) ? ramp_duty(lvl_m1[2:0]) : 8'd255;
      out_o.fast = (level_i > 8'd2);
    end
  end

endmodule

// ----- src/led_driver_mode_controller.sv -----
// Flashlight driver mode controller.
// Input channel (s_axis_*): one word per event. tuser carries the command
// (power-on, settle, voltage sample); tdata carries the short-press bit and
// the battery ADC reading. Output channel (m_axis_*): exactly one result word
// per accepted input word, in order, giving level code, ramp duty, fast-PWM
// flag, config-entry request, wear-level save slot, save strobe and shutdown.
// Configuration: cfg_we_i writes register cfg_index_i (0 group, 1 memory
// enable, 2 low-voltage threshold) with cfg_data_i; write only while idle.
// Timing: a result appears on m_axis_tvalid in the cycle after its input
// word is accepted. Throughput: one word per cycle when not stalled; the state
// update is a single registered pass and the output register refills in the
// cycle it drains. Stall: while the output word waits for m_axis_tready, the
// input still accepts if the waiting word is taken in that same cycle;
// otherwise s_axis_tready drops until the receiver takes the result.
// Reset: all mode state clears, threshold returns to 120, output empties.
module led_driver_mode_controller #(
  parameter int unsigned WEAR_SLOTS      = 32,
  parameter int unsigned RAMP_LEVELS     = 7,
  parameter int unsigned MODES_PER_GROUP = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [0] short_press, [8:1] voltage
  input  logic [1:0]  s_axis_tuser,  // [1:0] cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] mode_level, [15:8] pwm_duty, [16] fast_pwm, [17] enter_config,
  // [22:18] save_slot, [23] save_write, [24] shutdown
  output logic [31:0] m_axis_tdata
);
  import ldmc_pkg::*;

  `include "led_driver_mode_controller_macros.svh"

  // the save slot is five bits wide: slot counts above 32 wrap at 32
  localparam int unsigned SlotSpan  = (WEAR_SLOTS < 32) ? WEAR_SLOTS : 32;
  localparam logic [4:0] SlotLast   = 5'(SlotSpan - 1);
  localparam logic [4:0] ModeLimit  = 5'(MODES_PER_GROUP);
  localparam logic [7:0] RampMax    = 8'(RAMP_LEVELS);
  localparam logic [7:0] BlinkDrop  = 8'(RAMP_LEVELS / 2);

  // configuration registers
  logic [3:0] group_q;
  logic       mem_en_q;
  logic [7:0] thresh_q;

  // mode state
  logic [2:0]       mode_pos_q, mode_pos_d;
  logic [4:0]       fpc_q, fpc_d;
  logic [7:0]       level_q, level_d;
  logic [3:0]       lsc_q, lsc_d;
  logic [4:0]       slot_q, slot_d;
  logic             pdown_q, pdown_d;
  logic             cfg_req;
  logic             save_wr;

  // output register
  logic        out_valid_q;
  logic [31:0] out_data_q;

  logic       in_acc;
  cmd_e       cmd;
  logic       short_press;
  logic [7:0] voltage;
  logic [3:0] row;
  logic [4:0] row_n;
  logic [4:0] solid_n;
  logic [3:0] next_idx;
  logic [3:0] lsc_inc;
  level_out_t lvl_out;
  logic [4:0] slot_out;

  // accept whenever the output register is empty or draining this cycle
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign cmd         = cmd_e'(s_axis_tuser);
  assign short_press = s_axis_tdata[0];
  assign voltage     = s_axis_tdata[8:1];

  // rows past the table fall back to the first group
  assign row      = (group_q < 4'(GROUP_COUNT)) ? group_q : 4'd0;
  assign row_n    = {1'b0, row_solid_count(row)};
  assign solid_n  = (row_n < ModeLimit) ? row_n : ModeLimit;
  assign next_idx = {1'b0, mode_pos_q} + 4'd1;
  assign lsc_inc  = (lsc_q < 4'd15) ? (lsc_q + 4'd1) : lsc_q;

  always_comb begin
    mode_pos_d = mode_pos_q;
    fpc_d      = fpc_q;
    level_d    = level_q;
    lsc_d      = lsc_q;
    slot_d     = slot_q;
    pdown_d    = pdown_q;
    cfg_req    = 1'b0;
    save_wr    = 1'b0;
    case (cmd)
      CMD_POWER_ON: begin
        if (short_press) begin
          fpc_d      = fpc_q + 5'd1;
          mode_pos_d = ({1'b0, next_idx} >= solid_n) ? 3'd0 : next_idx[2:0];
        end else begin
          fpc_d = '0;
          if (!mem_en_q) begin
            mode_pos_d = '0;
          end
        end
        slot_d  = (slot_q == SlotLast) ? '0 : slot_q + 5'd1;
        save_wr = 1'b1;
        level_d = GROUP_TABLE[row][mode_pos_d];
        lsc_d   = '0;
        pdown_d = 1'b0;
        cfg_req = (fpc_d > 5'(CONFIG_PRESSES));
      end
      CMD_SETTLE: begin
        fpc_d = '0;
      end
      CMD_VSAMPLE: begin
        if (!pdown_q) begin
          lsc_d = (voltage < thresh_q) ? lsc_inc : 4'd0;
          // full low run: step down a level, blink to RAMP_LEVELS/2, else off
          if (lsc_d >= 4'(LOW_RUN)) begin
            if (level_q > RampMax) begin
              level_d = BlinkDrop;
            end else if (level_q > 8'd1) begin
              level_d = level_q - 8'd1;
            end else begin
              level_d = '0;
              pdown_d = 1'b1;
            end
            lsc_d = '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  ldmc_level_out #(
    .RAMP_LEVELS(RAMP_LEVELS)
  ) u_level_out (
    .level_i       (level_d),
    .powered_down_i(pdown_d),
    .out_o         (lvl_out)
  );

  assign slot_out = slot_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_q  <= '0;
      mem_en_q <= 1'b0;
      thresh_q <= THRESH_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_GROUP_SELECT: group_q  <= cfg_data_i[3:0];
        CFG_MEMORY_EN:    mem_en_q <= cfg_data_i[0];
        CFG_LOW_THRESH:   thresh_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // advance mode state only on an accepted word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_pos_q <= '0;
      fpc_q      <= '0;
      level_q    <= '0;
      lsc_q      <= '0;
      slot_q     <= '0;
      pdown_q    <= 1'b0;
    end else if (in_acc) begin
      mode_pos_q <= mode_pos_d;
      fpc_q      <= fpc_d;
      level_q    <= level_d;
      lsc_q      <= lsc_d;
      slot_q     <= slot_d;
      pdown_q    <= pdown_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // payload holds while stalled; load only with a fresh result
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_data_q <= {7'd0, pdown_d, save_wr, slot_out, cfg_req,
                     lvl_out.fast, lvl_out.duty, level_d};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  `LDMC_ASSERT_SAME(a_ready_when_empty, !out_valid_q, s_axis_tready,
                    "input stalled with empty output register")
  `LDMC_ASSERT_NEXT(a_power_on_saves, in_acc && (s_axis_tuser == CMD_POWER_ON),
                    m_axis_tvalid && m_axis_tdata[23] && !m_axis_tdata[24],
                    "power-on result lacks save strobe or reports shutdown")
  `LDMC_ASSERT_SAME(a_shutdown_dark, m_axis_tvalid && m_axis_tdata[24],
                    (m_axis_tdata[7:0] == 8'd0) && (m_axis_tdata[15:8] == 8'd0),
                    "shutdown result with light on")
  `LDMC_ASSERT_SAME(a_duty_solid, m_axis_tvalid && (m_axis_tdata[15:8] != 8'd0),
                    (m_axis_tdata[7:0] >= 8'd1) && (m_axis_tdata[7:0] <= RampMax),
                    "duty driven for a non-solid level")

endmodule
